FILE: hw/rtl/dpt5_pkg.sv
// Shared constants, codes and types of the top-5 inner product retrieval block.
`default_nettype none

package dpt5_pkg;

  // Default configuration
  localparam int FEATURE_DIM = 128;
  localparam int TOP_K       = 5;

  // Field widths
  localparam int OP_W    = 1;
  localparam int INDEX_W = 7;
  localparam int FEAT_W  = 16;
  localparam int ID_W    = 16;
  localparam int LABEL_W = 7;
  localparam int RANK_W  = 3;
  localparam int SCORE_W = 48;
  localparam int PROD_W  = 2 * FEAT_W;

  // Operation codes of an input word
  localparam logic [OP_W-1:0] OP_QUERY = 1'b0;
  localparam logic [OP_W-1:0] OP_BASE  = 1'b1;

  // Saturation bounds of the running sum
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // Queue between the scoring front and the ranking back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // One finished vector on its way to the ranking list
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
    logic [LABEL_W-1:0]        label;
    logic                      set_end;
  } score_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dpt5_in_if.sv
// Input channel: one query or base feature element per word.
`default_nettype none

interface dpt5_in_if;
  logic                              valid;
  logic                              ready;
  logic [dpt5_pkg::OP_W-1:0]         op;
  logic [dpt5_pkg::INDEX_W-1:0]      elem_index;
  logic signed [dpt5_pkg::FEAT_W-1:0] feature_value;
  logic [dpt5_pkg::ID_W-1:0]         item_id;
  logic [dpt5_pkg::LABEL_W-1:0]      class_label;
  logic                              vector_end;
  logic                              set_end;

  modport source (
    output valid, op, elem_index, feature_value, item_id, class_label, vector_end, set_end,
    input  ready
  );

  modport sink (
    input  valid, op, elem_index, feature_value, item_id, class_label, vector_end, set_end,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/dpt5_out_if.sv
// Result channel: one ranked match per word.
`default_nettype none

interface dpt5_out_if;
  logic                                valid;
  logic                                ready;
  logic [dpt5_pkg::RANK_W-1:0]         rank;
  logic [dpt5_pkg::ID_W-1:0]           match_id;
  logic [dpt5_pkg::LABEL_W-1:0]        match_label;
  logic signed [dpt5_pkg::SCORE_W-1:0] match_score;
  logic                                last;

  modport source (
    output valid, rank, match_id, match_label, match_score, last,
    input  ready
  );

  modport sink (
    input  valid, rank, match_id, match_label, match_score, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/dpt5_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dpt5_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dpt5_front.sv
// Scoring front: query store, multiply stage and saturating accumulator.
`default_nettype none

module dpt5_front #(
  parameter int FEATURE_DIM = dpt5_pkg::FEATURE_DIM
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  dpt5_in_if.sink                    items,
  output      logic                  push,
  output      dpt5_pkg::score_entry_t push_entry,
  input  wire logic                  queue_full
);

  localparam int ADDR_W  = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1;
  localparam int FEAT_W  = dpt5_pkg::FEAT_W;
  localparam int PROD_W  = dpt5_pkg::PROD_W;
  localparam int SCORE_W = dpt5_pkg::SCORE_W;
  localparam int ID_W    = dpt5_pkg::ID_W;
  localparam int LABEL_W = dpt5_pkg::LABEL_W;

  logic                      adv;
  logic                      accept;
  logic                      in_range;
  logic [ADDR_W-1:0]         addr;
  logic                      ram_we;
  logic                      ram_re;
  logic [FEAT_W-1:0]         q_rdata;
  logic signed [PROD_W-1:0]  prod_full;
  logic signed [SCORE_W:0]   sum_wide;
  logic signed [SCORE_W-1:0] sum_sat;

  // Lookup stage
  logic                      s1_valid;
  logic signed [FEAT_W-1:0]  s1_feat;
  logic                      s1_in_range;
  logic [ID_W-1:0]           s1_id;
  logic [LABEL_W-1:0]        s1_label;
  logic                      s1_vec_end;
  logic                      s1_set_end;

  // Product stage
  logic                      s2_valid;
  logic signed [PROD_W-1:0]  s2_prod;
  logic [ID_W-1:0]           s2_id;
  logic [LABEL_W-1:0]        s2_label;
  logic                      s2_vec_end;
  logic                      s2_set_end;

  logic signed [SCORE_W-1:0] running_sum;

  // Stall the whole pipe only when a finished vector meets a full queue
  assign adv         = !(s2_valid && s2_vec_end && queue_full);
  assign items.ready = adv;
  assign accept      = items.valid && adv;

  assign in_range = (32'(items.elem_index) < 32'(FEATURE_DIM));
  assign addr     = ADDR_W'(items.elem_index);
  assign ram_we   = accept && (items.op == dpt5_pkg::OP_QUERY) && in_range;
  assign ram_re   = accept && (items.op == dpt5_pkg::OP_BASE);

  dpt5_ram #(
    .WIDTH (FEAT_W),
    .DEPTH (FEATURE_DIM)
  ) u_query_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (items.feature_value),
    .re    (ram_re),
    .raddr (addr),
    .rdata (q_rdata)
  );

  // Advance the lookup stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= ram_re;
    end
    if (ram_re) begin
      s1_feat     <= items.feature_value;
      s1_in_range <= in_range;
      s1_id       <= items.item_id;
      s1_label    <= items.class_label;
      s1_vec_end  <= items.vector_end || items.set_end;
      s1_set_end  <= items.set_end;
    end
  end

  assign prod_full = $signed(q_rdata) * s1_feat;

  // Advance the product stage; out-of-range elements add nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv && s1_valid) begin
      s2_prod    <= s1_in_range ? prod_full : '0;
      s2_id      <= s1_id;
      s2_label   <= s1_label;
      s2_vec_end <= s1_vec_end;
      s2_set_end <= s1_set_end;
    end
  end

  // Saturating accumulate
  assign sum_wide = (SCORE_W+1)'(running_sum) + (SCORE_W+1)'(s2_prod);
  always_comb begin
    if (sum_wide[SCORE_W] != sum_wide[SCORE_W-1]) begin
      sum_sat = sum_wide[SCORE_W] ? dpt5_pkg::SCORE_MIN : dpt5_pkg::SCORE_MAX;
    end else begin
      sum_sat = sum_wide[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (adv && s2_valid) begin
      running_sum <= s2_vec_end ? '0 : sum_sat;
    end
  end

  // Hand a finished vector to the queue
  assign push               = adv && s2_valid && s2_vec_end;
  assign push_entry.score   = sum_sat;
  assign push_entry.id      = s2_id;
  assign push_entry.label   = s2_label;
  assign push_entry.set_end = s2_set_end;

endmodule

`default_nettype wire

FILE: hw/rtl/dpt5_queue.sv
// Short queue of finished vector scores between front and back.
`default_nettype none

module dpt5_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire dpt5_pkg::score_entry_t push_entry,
  output      logic                   full,
  input  wire logic                   pop,
  output      dpt5_pkg::score_entry_t pop_entry,
  output      logic                   not_empty
);

  localparam int DEPTH = dpt5_pkg::QUEUE_DEPTH;
  localparam int PTR_W = dpt5_pkg::QUEUE_PTR_W;
  localparam int CNT_W = dpt5_pkg::QUEUE_CNT_W;

  dpt5_pkg::score_entry_t slots [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = slots[rd_ptr];

  // Store incoming words
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dpt5_back.sv
// Ranking back: sorted top-K list, insertion and ranked result emission.
`default_nettype none

module dpt5_back #(
  parameter int TOP_K = dpt5_pkg::TOP_K
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire dpt5_pkg::score_entry_t entry,
  input  wire logic                   entry_valid,
  output      logic                   entry_pop,
  dpt5_out_if.source                  results
);

  localparam int CNT_W   = $clog2(TOP_K + 1);
  localparam int RANK_W  = dpt5_pkg::RANK_W;
  localparam int SCORE_W = dpt5_pkg::SCORE_W;
  localparam int ID_W    = dpt5_pkg::ID_W;
  localparam int LABEL_W = dpt5_pkg::LABEL_W;

  typedef enum logic {
    ST_INSERT,
    ST_EMIT
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          fill;
  logic [CNT_W-1:0]          emit_rank;
  logic signed [SCORE_W-1:0] best_score [TOP_K];
  logic [ID_W-1:0]           best_id    [TOP_K];
  logic [LABEL_W-1:0]        best_label [TOP_K];

  logic [TOP_K-1:0]          keep;
  logic signed [SCORE_W-1:0] ins_score  [TOP_K];
  logic [ID_W-1:0]           ins_id     [TOP_K];
  logic [LABEL_W-1:0]        ins_label  [TOP_K];
  logic [CNT_W-1:0]          ins_fill;
  logic                      out_free;

  assign entry_pop = (state == ST_INSERT) && entry_valid;
  assign out_free  = !results.valid || results.ready;

  // Entries that stay ahead of the new score: an equal score stays ahead
  always_comb begin
    for (int i = 0; i < TOP_K; i++) begin
      keep[i] = (CNT_W'(i) < fill) && (entry.score <= best_score[i]);
    end
  end

  // Build the list with the new entry placed and the tail moved down
  always_comb begin
    if (keep[0]) begin
      ins_score[0] = best_score[0];
      ins_id[0]    = best_id[0];
      ins_label[0] = best_label[0];
    end else begin
      ins_score[0] = entry.score;
      ins_id[0]    = entry.id;
      ins_label[0] = entry.label;
    end
    for (int i = 1; i < TOP_K; i++) begin
      if (keep[i]) begin
        ins_score[i] = best_score[i];
        ins_id[i]    = best_id[i];
        ins_label[i] = best_label[i];
      end else if (keep[i-1]) begin
        ins_score[i] = entry.score;
        ins_id[i]    = entry.id;
        ins_label[i] = entry.label;
      end else begin
        ins_score[i] = best_score[i-1];
        ins_id[i]    = best_id[i-1];
        ins_label[i] = best_label[i-1];
      end
    end
    ins_fill = (fill < CNT_W'(TOP_K)) ? fill + 1'b1 : fill;
  end

  // Insert scores, then drain the list head first once the set ends
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INSERT;
      fill          <= '0;
      emit_rank     <= '0;
      results.valid <= 1'b0;
    end else begin
      unique case (state)
        ST_INSERT: begin
          if (results.ready) begin
            results.valid <= 1'b0;
          end
          if (entry_valid) begin
            for (int i = 0; i < TOP_K; i++) begin
              best_score[i] <= ins_score[i];
              best_id[i]    <= ins_id[i];
              best_label[i] <= ins_label[i];
            end
            fill <= ins_fill;
            if (entry.set_end) begin
              state     <= ST_EMIT;
              emit_rank <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            results.valid       <= 1'b1;
            results.rank        <= RANK_W'(emit_rank);
            results.match_id    <= best_id[0];
            results.match_label <= best_label[0];
            results.match_score <= best_score[0];
            results.last        <= (fill == CNT_W'(1));
            for (int i = 0; i < TOP_K - 1; i++) begin
              best_score[i] <= best_score[i+1];
              best_id[i]    <= best_id[i+1];
              best_label[i] <= best_label[i+1];
            end
            best_score[TOP_K-1] <= '0;
            best_id[TOP_K-1]    <= '0;
            best_label[TOP_K-1] <= '0;
            fill      <= fill - 1'b1;
            emit_rank <= emit_rank + 1'b1;
            if (fill == CNT_W'(1)) begin
              state <= ST_INSERT;
            end
          end
        end
        default: begin
          state <= ST_INSERT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dot_product_top5_retrieval_core.sv
// Top level of the top-K maximum inner product retrieval block.
//
// Usage: the items channel carries one feature element per word. op selects
// a query load (writes the element into the query store) or a base element
// (multiplied with the stored query element and accumulated, saturating to
// 48 bits). vector_end closes a base vector and ranks its score against the
// best TOP_K held so far; an equal score keeps the older entry ahead.
// set_end closes the vector and the set: the list then leaves on the
// results channel, rank 0 first, one word per cycle while the receiver is
// ready, the final one marked by last, and the list is emptied.
// Throughput: one item per cycle, set by the single multiply-accumulate
// path (query RAM read, multiply stage, accumulate stage). The back end
// takes no new score from the queue while it drains the list. A four-entry
// queue lets the front keep streaming while results drain; items stall
// only once that queue fills. A set_end word passes the lookup stage, the
// product stage and the queue before the back end ranks it and registers
// the first result.
// Reset clears the pipeline, accumulator, queue and list; the query store
// keeps no reset value and must be loaded before use. When the receiver
// stalls, the result word holds and the queue then fills before items stall.
`default_nettype none

module dot_product_top5_retrieval_core #(
  parameter int FEATURE_DIM = dpt5_pkg::FEATURE_DIM,
  parameter int TOP_K       = dpt5_pkg::TOP_K
) (
  input wire logic   clk,
  input wire logic   rst,
  dpt5_in_if.sink    items,
  dpt5_out_if.source results
);

  logic                   push;
  dpt5_pkg::score_entry_t push_entry;
  logic                   queue_full;
  logic                   pop;
  dpt5_pkg::score_entry_t pop_entry;
  logic                   not_empty;

  dpt5_front #(
    .FEATURE_DIM (FEATURE_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  dpt5_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (not_empty)
  );

  dpt5_back #(
    .TOP_K (TOP_K)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (pop_entry),
    .entry_valid (not_empty),
    .entry_pop   (pop),
    .results     (results)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/dpt5_checker.sv
// Port-level checks of the retrieval block's result stream, bound to the top level.
`default_nettype none

module dpt5_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [dpt5_pkg::RANK_W-1:0]         rank,
  input wire logic [dpt5_pkg::ID_W-1:0]           match_id,
  input wire logic signed [dpt5_pkg::SCORE_W-1:0] match_score,
  input wire logic                                last
);

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rank) && $stable(match_id)
      && $stable(match_score) && $stable(last))
    else $error("result word changed while stalled");

  // A run continues without gaps, ranks counting up
  a_rank_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && (rank == $past(rank) + 1'b1))
    else $error("ranked results not consecutive");

  // Scores never rise within a run
  a_descending: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> match_score <= $past(match_score))
    else $error("ranked scores not descending");

  // Nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind dot_product_top5_retrieval_core dpt5_checker u_dpt5_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .rank        (results.rank),
  .match_id    (results.match_id),
  .match_score (results.match_score),
  .last        (results.last)
);

`default_nettype wire

FILE: test/tb_dot_product_top5_retrieval_core.sv
// Self-checking testbench of the top-5 inner product retrieval core.
module tb_dot_product_top5_retrieval_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FEATURE_DIM = dpt5_pkg::FEATURE_DIM;
  localparam int TOP_K       = dpt5_pkg::TOP_K;
  localparam int OP_W        = dpt5_pkg::OP_W;
  localparam int INDEX_W     = dpt5_pkg::INDEX_W;
  localparam int FEAT_W      = dpt5_pkg::FEAT_W;
  localparam int ID_W        = dpt5_pkg::ID_W;
  localparam int LABEL_W     = dpt5_pkg::LABEL_W;
  localparam int RANK_W      = dpt5_pkg::RANK_W;
  localparam int SCORE_W     = dpt5_pkg::SCORE_W;

  localparam int IDLE_PCT     = 35;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_WORDS = 200;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [INDEX_W-1:0]        elem_index;
    logic signed [FEAT_W-1:0]  feature_value;
    logic [ID_W-1:0]           item_id;
    logic [LABEL_W-1:0]        class_label;
    logic                      vector_end;
    logic                      set_end;
  } elem_word_t;

  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic [ID_W-1:0]           match_id;
    logic [LABEL_W-1:0]        match_label;
    logic signed [SCORE_W-1:0] match_score;
    logic                      last;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dpt5_in_if  items ();
  dpt5_out_if results ();

  dot_product_top5_retrieval_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results)
  );

  always #2 clk = ~clk;

  // Words waiting to be sent and ranked matches waiting to arrive
  elem_word_t elem_words[$];
  match_t     ranked_expect[$];
  elem_word_t next_word;
  elem_word_t taken_word;
  match_t     want_match;

  // Own copy of the query, running sum and top list
  logic signed [FEAT_W-1:0] query_mem [FEATURE_DIM];
  longint                   dot_acc = 0;
  longint                   top_score [TOP_K];
  logic [ID_W-1:0]          top_id    [TOP_K];
  logic [LABEL_W-1:0]       top_label [TOP_K];
  int                       top_fill = 0;

  int unsigned accepted_words  = 0;
  int unsigned total_words     = 0;
  int unsigned results_checked = 0;
  int unsigned sets_closed     = 0;
  int unsigned errors          = 0;
  int unsigned calm_lo         = '1;
  int unsigned calm_hi         = 0;
  int unsigned hold_at         = '1;
  int unsigned hold_left       = 0;
  int unsigned stall_cycles    = 0;
  logic        hold_done       = 1'b0;
  logic        in_fire         = 1'b0;
  logic        calm;

  // Window in which neither side idles
  assign calm = (accepted_words >= calm_lo) && (accepted_words < calm_hi);

  // Score one accepted word; queue the ranked list when a set closes
  function automatic void score_word(input elem_word_t w);
    longint sum;
    int     pos;
    int     i;
    match_t m;
    if (w.op == dpt5_pkg::OP_QUERY) begin
      if (w.elem_index < FEATURE_DIM) query_mem[w.elem_index] = w.feature_value;
      return;
    end
    if (w.elem_index < FEATURE_DIM) begin
      sum = dot_acc + longint'($signed(query_mem[w.elem_index])) *
            longint'($signed(w.feature_value));
      if (sum > longint'(dpt5_pkg::SCORE_MAX)) sum = longint'(dpt5_pkg::SCORE_MAX);
      else if (sum < longint'(dpt5_pkg::SCORE_MIN)) sum = longint'(dpt5_pkg::SCORE_MIN);
      dot_acc = sum;
    end
    // Insert behind every entry that is not beaten; drop past the end
    if (w.vector_end || w.set_end) begin
      pos = 0;
      while (pos < top_fill && dot_acc <= top_score[pos]) pos++;
      if (pos < TOP_K) begin
        for (i = (top_fill < TOP_K) ? top_fill : TOP_K - 1; i > pos; i--) begin
          top_score[i] = top_score[i-1];
          top_id[i]    = top_id[i-1];
          top_label[i] = top_label[i-1];
        end
        top_score[pos] = dot_acc;
        top_id[pos]    = w.item_id;
        top_label[pos] = w.class_label;
        if (top_fill < TOP_K) top_fill++;
      end
      dot_acc = 0;
    end
    if (w.set_end) begin
      for (i = 0; i < top_fill; i++) begin
        m.rank        = RANK_W'(i);
        m.match_id    = top_id[i];
        m.match_label = top_label[i];
        m.match_score = SCORE_W'(top_score[i]);
        m.last        = (i == top_fill - 1);
        ranked_expect.insert(ranked_expect.size(), m);
      end
      for (i = 0; i < TOP_K; i++) begin
        top_score[i] = 0;
        top_id[i]    = '0;
        top_label[i] = '0;
      end
      top_fill = 0;
      sets_closed++;
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic logic [FEAT_W-1:0] pick_feat();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return FEAT_W'($urandom);
    endcase
  endfunction

  // Marks, id and label of a query load are noise
  task automatic push_query(input int idx, input logic [FEAT_W-1:0] feat);
    elem_word_t w;
    w.op            = dpt5_pkg::OP_QUERY;
    w.elem_index    = INDEX_W'(idx);
    w.feature_value = feat;
    w.item_id       = ID_W'($urandom);
    w.class_label   = LABEL_W'($urandom);
    w.vector_end    = 1'($urandom_range(1));
    w.set_end       = 1'($urandom_range(1));
    elem_words.insert(elem_words.size(), w);
  endtask

  task automatic push_base(input int idx, input logic [FEAT_W-1:0] feat,
                           input logic [ID_W-1:0] id, input logic [LABEL_W-1:0] label,
                           input logic vend, input logic send);
    elem_word_t w;
    w.op            = dpt5_pkg::OP_BASE;
    w.elem_index    = INDEX_W'(idx);
    w.feature_value = feat;
    w.item_id       = id;
    w.class_label   = label;
    w.vector_end    = vend;
    w.set_end       = send;
    elem_words.insert(elem_words.size(), w);
  endtask

  // Driver: advance to the next word once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      items.valid         <= 1'b0;
      items.op            <= dpt5_pkg::OP_QUERY;
      items.elem_index    <= '0;
      items.feature_value <= '0;
      items.item_id       <= '0;
      items.class_label   <= '0;
      items.vector_end    <= 1'b0;
      items.set_end       <= 1'b0;
    end else if (!items.valid || in_fire) begin
      if (elem_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_word = elem_words.pop_front();
        items.op            <= next_word.op;
        items.elem_index    <= next_word.elem_index;
        items.feature_value <= next_word.feature_value;
        items.item_id       <= next_word.item_id;
        items.class_label   <= next_word.class_label;
        items.vector_end    <= next_word.vector_end;
        items.set_end       <= next_word.set_end;
        items.valid         <= 1'b1;
      end else begin
        items.valid <= 1'b0;
      end
    end
  end

  // Receiver: hold off once for a long stretch, otherwise stall at random
  always @(negedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      results.ready <= 1'b0;
    end else if (!hold_done && accepted_words >= hold_at) begin
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
      results.ready <= 1'b0;
    end else begin
      results.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: score accepted words, check accepted results against the oldest match
  always @(posedge clk) begin
    in_fire <= !rst && items.valid && items.ready;
    if (!rst && items.valid && items.ready) begin
      taken_word.op            = items.op;
      taken_word.elem_index    = items.elem_index;
      taken_word.feature_value = items.feature_value;
      taken_word.item_id       = items.item_id;
      taken_word.class_label   = items.class_label;
      taken_word.vector_end    = items.vector_end;
      taken_word.set_end       = items.set_end;
      score_word(taken_word);
      accepted_words++;
    end
    if (!rst && results.valid && results.ready) begin
      if (ranked_expect.size() == 0) begin
        $error("unexpected result word: rank %0d id %0h", results.rank, results.match_id);
        errors++;
      end else begin
        want_match = ranked_expect.pop_front();
        check_field("rank", 64'(want_match.rank), 64'(results.rank));
        check_field("match_id", 64'(want_match.match_id), 64'(results.match_id));
        check_field("match_label", 64'(want_match.match_label), 64'(results.match_label));
        check_field("match_score", 64'(want_match.match_score), 64'(results.match_score));
        check_field("last", 64'(want_match.last), 64'(results.last));
      end
      results_checked++;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int          e;
    int          v;
    int          nvec;
    int          len;
    int unsigned rand_start;
    logic [ID_W-1:0]    id;
    logic [LABEL_W-1:0] label;
    logic        zero_vec;
    logic        close_vec;
    logic        close_set;

    // Load every query element first so no base word reads an empty slot
    for (e = 0; e < FEATURE_DIM; e++) push_query(e, pick_feat());
    push_query(0, 16'h7FFF);
    push_query(1, 16'h8000);
    push_query(2, 16'h0100);
    push_query(FEATURE_DIM - 1, 16'hFFFF);

    // Eight vectors: extremes, equal scores, a full list, set end without vector end
    push_base(0, 16'h8000, 16'hFFFF, 7'h7F, 1'b1, 1'b0);
    push_base(1, 16'h8000, 16'h0001, 7'h00, 1'b0, 1'b0);
    push_base(0, 16'h7FFF, 16'h0001, 7'h00, 1'b1, 1'b0);
    push_base(FEATURE_DIM - 1, 16'h0000, 16'h0002, 7'h01, 1'b1, 1'b0);
    push_base(2, 16'h0000, 16'h0003, 7'h02, 1'b1, 1'b0);
    push_base(2, 16'h0001, 16'h0004, 7'h03, 1'b1, 1'b0);
    push_base(FEATURE_DIM - 1, 16'h0001, 16'h0005, 7'h04, 1'b1, 1'b0);
    push_base(2, 16'h0000, 16'h0006, 7'h05, 1'b1, 1'b0);
    push_base(2, 16'h0000, 16'h0007, 7'h06, 1'b0, 1'b1);
    // Single-vector set closed by set end alone
    push_base(1, 16'h7FFF, 16'hABCD, 7'h55, 1'b0, 1'b1);

    // Random sets of mostly short vectors, with stray query reloads as noise
    rand_start = elem_words.size();
    calm_lo    = rand_start;
    calm_hi    = rand_start + 80;
    hold_at    = rand_start + 100;
    while (elem_words.size() < rand_start + RANDOM_WORDS) begin
      nvec = $urandom_range(1, 8);
      for (v = 0; v < nvec; v++) begin
        len      = ($urandom_range(9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
        id       = ID_W'($urandom);
        label    = LABEL_W'($urandom);
        zero_vec = ($urandom_range(4) == 0);
        for (e = 0; e < len; e++) begin
          if ($urandom_range(9) == 0) push_query($urandom_range(FEATURE_DIM - 1), pick_feat());
          close_vec = (e == len - 1);
          close_set = close_vec && (v == nvec - 1);
          push_base($urandom_range(FEATURE_DIM - 1), zero_vec ? FEAT_W'(0) : pick_feat(),
                    id, label, close_vec && !(close_set && $urandom_range(1) != 0),
                    close_set);
        end
      end
    end
    total_words = elem_words.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last word and every ranked match, then let the pipe drain
    while (accepted_words < total_words || ranked_expect.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d words in %0d sets, incl. tied scores, full lists and a long output stall;",
             total_words, sets_closed);
    $display("checked %0d ranked results, %0d mismatches.", results_checked, errors);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
